/* sv/mts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, register codes, band limits and relay patterns for the mains
// tap selector.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int VOLT_BITS_DEF = 9;
    localparam int BAND_W        = 9;
    localparam int CONFIRM_W     = 3;
    localparam int HOLD_W        = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int PINS_W        = 6;
    localparam int NUM_BANDS     = 4;

    localparam int FAIL_HIGH_RST = 280;
    localparam int FAIL_LOW_RST  = 170;
    localparam int OK_HIGH_RST   = 270;
    localparam int OK_LOW_RST    = 180;
    localparam int CONFIRM_RST   = 5;
    localparam int HOLD_RST      = 35;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAIL_HIGH = 3'd0,
        CFG_FAIL_LOW  = 3'd1,
        CFG_OK_HIGH   = 3'd2,
        CFG_OK_LOW    = 3'd3,
        CFG_CONFIRM   = 3'd4,
        CFG_HOLD      = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        TAP_NONE     = 3'd0,
        TAP_BUCK     = 3'd1,
        TAP_NORMAL_1 = 3'd2,
        TAP_NORMAL   = 3'd3,
        TAP_BOOST    = 3'd4
    } t_tap;

    typedef struct packed {
        logic [CONFIRM_W-1:0] confirm;
        logic [HOLD_W-1:0]    hold;
    } t_timing;

    // exclusive band edges: buck, normal_1, normal, boost
    localparam logic [BAND_W-1:0] BAND_LO [NUM_BANDS] = '{9'd180, 9'd202, 9'd222, 9'd242};
    localparam logic [BAND_W-1:0] BAND_HI [NUM_BANDS] = '{9'd200, 9'd220, 9'd240, 9'd270};

    // active-low indicator and relay pins for a tap
    function automatic logic [PINS_W-1:0] tap_pins(input t_tap tap);
        logic [PINS_W-1:0] pins;
        case (tap)
            TAP_BUCK:     pins = 6'h39;
            TAP_NORMAL_1: pins = 6'h33;
            TAP_NORMAL:   pins = 6'h2B;
            TAP_BOOST:    pins = 6'h1E;
            default:      pins = 6'h00;
        endcase
        return pins;
    endfunction

endpackage

/* sv/mts_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_cfg_regs
// Window thresholds, confirm count and failure hold time, written through a
// plain write port.
// ----------------------------------------------------------------------------
module mts_cfg_regs #(
    parameter int VOLT_BITS = mts_pkg::VOLT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] i_cfg_data,
    output logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] o_fail_high,
    output logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] o_fail_low,
    output logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] o_ok_high,
    output logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] o_ok_low,
    output mts_pkg::t_timing                    o_timing
);

    localparam int CMP_W = (VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W;

    logic [CMP_W-1:0]        r_fail_high;
    logic [CMP_W-1:0]        r_fail_low;
    logic [CMP_W-1:0]        r_ok_high;
    logic [CMP_W-1:0]        r_ok_low;
    mts_pkg::t_timing        r_timing;
    logic [CMP_W-1:0]        wr_volt;

    assign wr_volt = CMP_W'(i_cfg_data[VOLT_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_high      <= CMP_W'(mts_pkg::FAIL_HIGH_RST);
            r_fail_low       <= CMP_W'(mts_pkg::FAIL_LOW_RST);
            r_ok_high        <= CMP_W'(mts_pkg::OK_HIGH_RST);
            r_ok_low         <= CMP_W'(mts_pkg::OK_LOW_RST);
            r_timing.confirm <= mts_pkg::CONFIRM_W'(mts_pkg::CONFIRM_RST);
            r_timing.hold    <= mts_pkg::HOLD_W'(mts_pkg::HOLD_RST);
        end else if (i_cfg_we) begin
            case (mts_pkg::t_cfg_idx'(i_cfg_index))
                mts_pkg::CFG_FAIL_HIGH: r_fail_high      <= wr_volt;
                mts_pkg::CFG_FAIL_LOW:  r_fail_low       <= wr_volt;
                mts_pkg::CFG_OK_HIGH:   r_ok_high        <= wr_volt;
                mts_pkg::CFG_OK_LOW:    r_ok_low         <= wr_volt;
                mts_pkg::CFG_CONFIRM:   r_timing.confirm <= i_cfg_data[mts_pkg::CONFIRM_W-1:0];
                mts_pkg::CFG_HOLD:      r_timing.hold    <= i_cfg_data[mts_pkg::HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_fail_high = r_fail_high;
    assign o_fail_low  = r_fail_low;
    assign o_ok_high   = r_ok_high;
    assign o_ok_low    = r_ok_low;
    assign o_timing    = r_timing;

endmodule

/* sv/mts_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_core
// Window classification, fail/ok/band counters, hold timer and the result
// register holding the selected tap and its pin pattern.
// ----------------------------------------------------------------------------
module mts_core #(
    parameter int VOLT_BITS = mts_pkg::VOLT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [VOLT_BITS-1:0]                i_sample,
    input  logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] i_fail_high,
    input  logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] i_fail_low,
    input  logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] i_ok_high,
    input  logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] i_ok_low,
    input  mts_pkg::t_timing                    i_timing,
    output logic [2:0]                          o_tap_select,
    output logic [mts_pkg::PINS_W-1:0]          o_drive_pattern,
    output logic                                o_sample_ok,
    output logic                                o_mains_failed,
    output logic                                o_failure_pending
);

    localparam int CMP_W = (VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W;
    localparam int CW    = mts_pkg::CONFIRM_W;
    localparam int HW    = mts_pkg::HOLD_W;
    localparam int NB    = mts_pkg::NUM_BANDS;

    logic [CW-1:0]              r_fail_cnt, n_fail_cnt;
    logic [CW-1:0]              r_ok_cnt, n_ok_cnt;
    logic [CW-1:0]              r_band_cnt [NB];
    logic [CW-1:0]              n_band_cnt [NB];
    mts_pkg::t_tap              r_tap, n_tap;
    logic                       r_failed, n_failed;
    logic                       r_pending, n_pending;
    logic [HW-1:0]              r_hold_cnt, n_hold_cnt;
    logic                       r_ok_flag, n_ok_flag;
    logic [mts_pkg::PINS_W-1:0] r_drive;

    logic [CMP_W-1:0]           s_ext;
    logic                       fail_hit;
    logic                       ok_hit;
    logic [CW:0]                fail_inc;
    logic [CW:0]                ok_inc;
    logic [CW:0]                band_inc [NB];
    logic [HW:0]                hold_inc;

    assign s_ext    = CMP_W'(i_sample);
    assign fail_hit = (s_ext > i_fail_high) || (s_ext < i_fail_low);
    assign ok_hit   = (s_ext < i_ok_high) && (s_ext > i_ok_low);
    assign fail_inc = {1'b0, r_fail_cnt} + (CW+1)'(1);
    assign ok_inc   = {1'b0, r_ok_cnt} + (CW+1)'(1);
    assign hold_inc = {1'b0, r_hold_cnt} + (HW+1)'(1);

    always_comb begin
        n_fail_cnt = r_fail_cnt;
        n_ok_cnt   = r_ok_cnt;
        n_tap      = r_tap;
        n_failed   = r_failed;
        n_pending  = r_pending;
        n_hold_cnt = r_hold_cnt;
        n_ok_flag  = r_ok_flag;
        for (int b = 0; b < NB; b++) begin
            n_band_cnt[b] = r_band_cnt[b];
            band_inc[b]   = {1'b0, r_band_cnt[b]} + (CW+1)'(1);
        end

        // fail window takes priority over recovery window
        if (fail_hit) begin
            n_ok_flag = 1'b0;
            if (fail_inc > {1'b0, i_timing.confirm}) begin
                n_fail_cnt = '0;
                n_ok_cnt   = '0;
                n_pending  = 1'b1;
            end else begin
                n_fail_cnt = fail_inc[CW-1:0];
            end
        end else if (ok_hit) begin
            n_ok_flag = 1'b1;
            if (ok_inc >= {1'b0, i_timing.confirm}) begin
                n_ok_cnt   = '0;
                n_fail_cnt = '0;
                n_failed   = 1'b0;
            end else begin
                n_ok_cnt = ok_inc[CW-1:0];
            end
        end

        // tap bands frozen while failed
        if (!n_failed) begin
            for (int b = 0; b < NB; b++) begin
                if ((s_ext > CMP_W'(mts_pkg::BAND_LO[b])) &&
                    (s_ext < CMP_W'(mts_pkg::BAND_HI[b]))) begin
                    if (band_inc[b] >= {1'b0, i_timing.confirm}) begin
                        n_band_cnt[b] = '0;
                        n_tap         = mts_pkg::t_tap'(3'(b + 1));
                    end else begin
                        n_band_cnt[b] = band_inc[b][CW-1:0];
                    end
                end
            end
        end

        if (n_pending) begin
            if (hold_inc >= {1'b0, i_timing.hold}) begin
                n_failed   = 1'b1;
                n_pending  = 1'b0;
                n_hold_cnt = '0;
            end else begin
                n_hold_cnt = hold_inc[HW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_cnt <= '0;
            r_ok_cnt   <= '0;
            r_tap      <= mts_pkg::TAP_NONE;
            r_failed   <= 1'b0;
            r_pending  <= 1'b0;
            r_hold_cnt <= '0;
            r_ok_flag  <= 1'b0;
            r_drive    <= '0;
            for (int b = 0; b < NB; b++) begin
                r_band_cnt[b] <= '0;
            end
        end else if (i_load) begin
            r_fail_cnt <= n_fail_cnt;
            r_ok_cnt   <= n_ok_cnt;
            r_tap      <= n_tap;
            r_failed   <= n_failed;
            r_pending  <= n_pending;
            r_hold_cnt <= n_hold_cnt;
            r_ok_flag  <= n_ok_flag;
            r_drive    <= mts_pkg::tap_pins(n_tap);
            for (int b = 0; b < NB; b++) begin
                r_band_cnt[b] <= n_band_cnt[b];
            end
        end
    end

    assign o_tap_select      = r_tap;
    assign o_drive_pattern   = r_drive;
    assign o_sample_ok       = r_ok_flag;
    assign o_mains_failed    = r_failed;
    assign o_failure_pending = r_pending;

endmodule

/* sv/mains_tap_selector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mains_tap_selector_unit
// Mains tap controller: classifies voltage samples, tracks failure and
// recovery, and selects the stabiliser tap with its relay pattern.
//
// Sample channel: i_sample_valid / o_sample_ready carry one voltage beat.
// Result channel: o_result_valid / i_result_ready carry one result beat per
// sample: selected tap, active-low drive pattern and status flags, all as
// they stand after that sample.
// Path: an accepted sample lands in the input register, and its result is
// valid once the result register takes it together with the controller
// state, which waits while the result register is full and not read.
// Throughput: one sample per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input
// register takes one more beat; the sample side stalls only when both are
// full. Configuration writes are taken in any cycle and are meant for idle
// periods only.
// Reset: thresholds return to their defaults, all counters and flags clear,
// no tap is selected and both registers are empty.
// ----------------------------------------------------------------------------
module mains_tap_selector_unit #(
    parameter int VOLT_BITS = mts_pkg::VOLT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [((VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W)-1:0] i_cfg_data,
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic [VOLT_BITS-1:0]                i_voltage_sample,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic [2:0]                          o_tap_select,
    output logic [mts_pkg::PINS_W-1:0]          o_drive_pattern,
    output logic                                o_sample_ok,
    output logic                                o_mains_failed,
    output logic                                o_failure_pending
);

    localparam int CMP_W = (VOLT_BITS > mts_pkg::BAND_W) ? VOLT_BITS : mts_pkg::BAND_W;

    logic [CMP_W-1:0]       fail_high;
    logic [CMP_W-1:0]       fail_low;
    logic [CMP_W-1:0]       ok_high;
    logic [CMP_W-1:0]       ok_low;
    mts_pkg::t_timing       timing;

    logic                   r_in_valid;
    logic [VOLT_BITS-1:0]   r_in_sample;
    logic                   r_out_valid;
    logic                   load;
    logic                   in_take;

    assign load           = r_in_valid && (!r_out_valid || i_result_ready);
    assign o_sample_ready = !r_in_valid || load;
    assign in_take        = i_sample_valid && o_sample_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_voltage_sample;
        end
    end

    mts_cfg_regs #(
        .VOLT_BITS   (VOLT_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_high (fail_high),
        .o_fail_low  (fail_low),
        .o_ok_high   (ok_high),
        .o_ok_low    (ok_low),
        .o_timing    (timing)
    );

    mts_core #(
        .VOLT_BITS         (VOLT_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (load),
        .i_sample          (r_in_sample),
        .i_fail_high       (fail_high),
        .i_fail_low        (fail_low),
        .i_ok_high         (ok_high),
        .i_ok_low          (ok_low),
        .i_timing          (timing),
        .o_tap_select      (o_tap_select),
        .o_drive_pattern   (o_drive_pattern),
        .o_sample_ok       (o_sample_ok),
        .o_mains_failed    (o_mains_failed),
        .o_failure_pending (o_failure_pending)
    );

    assign o_result_valid = r_out_valid;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mains tap selector unit.
//
// A short table of directed samples walks the block through every tap band,
// both failure edges and the window limits. Random runs of in-band, failing,
// recovering and noisy samples then follow under several threshold, confirm
// and hold settings. Zero and maximum confirm and hold values, lowered
// thresholds and overlapping or empty windows are among these settings.
// A behavioural model of the controller predicts each result beat, and every
// beat is compared field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 100;
    localparam int NUM_PHASES     = 8;
    localparam int VMAX           = 511;

    typedef struct packed {
        mts_pkg::t_tap tap;
        logic [5:0]    pins;
        logic          ok;
        logic          failed;
        logic          pending;
    } t_status;

    typedef struct packed {
        logic [8:0] volt;
        logic       fixed;
        t_status    want;
    } t_vec;

    localparam t_status ST_ANY    = '0;
    localparam t_status ST_IDLE   = '{mts_pkg::TAP_NONE, 6'h00, 1'b0, 1'b0, 1'b0};
    localparam t_status ST_IDLEOK = '{mts_pkg::TAP_NONE, 6'h00, 1'b1, 1'b0, 1'b0};
    localparam t_status ST_BUCK   = '{mts_pkg::TAP_BUCK, 6'h39, 1'b1, 1'b0, 1'b0};
    localparam t_status ST_NORM1  = '{mts_pkg::TAP_NORMAL_1, 6'h33, 1'b1, 1'b0, 1'b0};
    localparam t_status ST_NORM   = '{mts_pkg::TAP_NORMAL, 6'h2B, 1'b1, 1'b0, 1'b0};
    localparam t_status ST_BOOST  = '{mts_pkg::TAP_BOOST, 6'h1E, 1'b1, 1'b0, 1'b0};

    localparam t_vec DIRECTED [25] = '{
        '{9'd0,   1'b1, ST_IDLE},   '{9'd511, 1'b1, ST_IDLE},
        '{9'd190, 1'b1, ST_IDLEOK}, '{9'd190, 1'b0, ST_ANY},
        '{9'd190, 1'b0, ST_ANY},    '{9'd190, 1'b0, ST_ANY},
        '{9'd190, 1'b1, ST_BUCK},
        '{9'd210, 1'b0, ST_ANY},    '{9'd210, 1'b0, ST_ANY},
        '{9'd210, 1'b0, ST_ANY},    '{9'd210, 1'b0, ST_ANY},
        '{9'd210, 1'b1, ST_NORM1},
        '{9'd230, 1'b0, ST_ANY},    '{9'd230, 1'b0, ST_ANY},
        '{9'd230, 1'b0, ST_ANY},    '{9'd230, 1'b0, ST_ANY},
        '{9'd230, 1'b1, ST_NORM},
        '{9'd260, 1'b0, ST_ANY},    '{9'd260, 1'b0, ST_ANY},
        '{9'd260, 1'b0, ST_ANY},    '{9'd260, 1'b0, ST_ANY},
        '{9'd260, 1'b1, ST_BOOST},
        '{9'd280, 1'b0, ST_ANY},    '{9'd200, 1'b0, ST_ANY},
        '{9'd170, 1'b0, ST_ANY}
    };

    // fail high, fail low, ok high, ok low, confirm, hold per phase
    localparam int PH_FH [NUM_PHASES] = '{280, 280, 280, 511,   0, 300, 250, 280};
    localparam int PH_FL [NUM_PHASES] = '{170, 170, 170,   0, 511, 150, 200, 170};
    localparam int PH_OH [NUM_PHASES] = '{270, 270, 270, 511,   0, 290, 260, 270};
    localparam int PH_OL [NUM_PHASES] = '{180, 180, 180,   0, 511, 160, 190, 180};
    localparam int PH_CF [NUM_PHASES] = '{  5,   7,   2,   1,   0,   3,   2,   0};
    localparam int PH_HD [NUM_PHASES] = '{ 35,  63,   5,   1,   0,   4,  10,   0};

    localparam int         BAND_FLOOR [4] = '{180, 202, 222, 242};
    localparam int         BAND_CEIL  [4] = '{200, 220, 240, 270};
    localparam logic [5:0] PIN_MAP    [8] = '{6'h00, 6'h39, 6'h33, 6'h2B, 6'h1E,
                                              6'h00, 6'h00, 6'h00};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    mts_pkg::t_cfg_idx i_cfg_index;
    logic [8:0]        i_cfg_data;
    logic              i_sample_valid;
    logic              o_sample_ready;
    logic [8:0]        i_voltage_sample;
    logic              o_result_valid;
    logic              i_result_ready;
    logic [2:0]        o_tap_select;
    logic [5:0]        o_drive_pattern;
    logic              o_sample_ok;
    logic              o_mains_failed;
    logic              o_failure_pending;

    // controller model: thresholds and state
    logic [8:0]    lim_fail_hi, lim_fail_lo, lim_ok_hi, lim_ok_lo;
    logic [2:0]    confirm_n;
    logic [5:0]    hold_n;
    logic [2:0]    fail_cnt, ok_cnt;
    logic [2:0]    band_cnt [4];
    mts_pkg::t_tap cur_tap;
    logic          failed_q, pending_q, ok_q;
    logic [5:0]    hold_cnt;

    t_status awaited_status_q [$];
    bit      sender_idle, recv_idle;
    int      mismatches   = 0;
    int      n_samples    = 0;
    int      n_results    = 0;
    int      n_failures   = 0;
    int      n_recoveries = 0;
    logic    prev_failed  = 1'b0;
    logic [4:0] taps_seen = '0;
    int      quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    mains_tap_selector_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample_valid   (i_sample_valid),
        .o_sample_ready   (o_sample_ready),
        .i_voltage_sample (i_voltage_sample),
        .o_result_valid   (o_result_valid),
        .i_result_ready   (i_result_ready),
        .o_tap_select     (o_tap_select),
        .o_drive_pattern  (o_drive_pattern),
        .o_sample_ok      (o_sample_ok),
        .o_mains_failed   (o_mains_failed),
        .o_failure_pending(o_failure_pending)
    );

    function automatic void clear_model();
        lim_fail_hi = 9'(mts_pkg::FAIL_HIGH_RST);
        lim_fail_lo = 9'(mts_pkg::FAIL_LOW_RST);
        lim_ok_hi   = 9'(mts_pkg::OK_HIGH_RST);
        lim_ok_lo   = 9'(mts_pkg::OK_LOW_RST);
        confirm_n   = 3'(mts_pkg::CONFIRM_RST);
        hold_n      = 6'(mts_pkg::HOLD_RST);
        fail_cnt    = '0;
        ok_cnt      = '0;
        for (int b = 0; b < 4; b++) band_cnt[b] = '0;
        cur_tap     = mts_pkg::TAP_NONE;
        failed_q    = 1'b0;
        pending_q   = 1'b0;
        hold_cnt    = '0;
        ok_q        = 1'b0;
    endfunction

    function automatic t_status next_status(input logic [8:0] v);
        int n;
        if (v > lim_fail_hi || v < lim_fail_lo) begin
            ok_q = 1'b0;
            n = int'(fail_cnt) + 1;
            if (n > int'(confirm_n)) begin
                fail_cnt  = '0;
                ok_cnt    = '0;
                pending_q = 1'b1;
            end else begin
                fail_cnt = n[2:0];
            end
        end else if (v < lim_ok_hi && v > lim_ok_lo) begin
            ok_q = 1'b1;
            n = int'(ok_cnt) + 1;
            if (n >= int'(confirm_n)) begin
                ok_cnt   = '0;
                fail_cnt = '0;
                failed_q = 1'b0;
            end else begin
                ok_cnt = n[2:0];
            end
        end
        if (!failed_q) begin
            for (int b = 0; b < 4; b++) begin
                if (int'(v) > BAND_FLOOR[b] && int'(v) < BAND_CEIL[b]) begin
                    n = int'(band_cnt[b]) + 1;
                    if (n >= int'(confirm_n)) begin
                        band_cnt[b] = '0;
                        cur_tap     = mts_pkg::t_tap'(3'(b + 1));
                    end else begin
                        band_cnt[b] = n[2:0];
                    end
                end
            end
        end
        if (pending_q) begin
            n = int'(hold_cnt) + 1;
            if (n >= int'(hold_n)) begin
                failed_q  = 1'b1;
                hold_cnt  = '0;
                pending_q = 1'b0;
            end else begin
                hold_cnt = n[5:0];
            end
        end
        return '{cur_tap, PIN_MAP[cur_tap], ok_q, failed_q, pending_q};
    endfunction

    function automatic logic [8:0] pick_fail();
        if (lim_fail_lo > 0 && (lim_fail_hi == VMAX || $urandom_range(0, 1) == 0))
            return 9'($urandom_range(int'(lim_fail_lo) - 1, 0));
        if (lim_fail_hi < VMAX)
            return 9'($urandom_range(VMAX, int'(lim_fail_hi) + 1));
        return 9'($urandom_range(VMAX, 0));
    endfunction

    function automatic logic [8:0] pick_ok();
        if (int'(lim_ok_hi) > int'(lim_ok_lo) + 1)
            return 9'($urandom_range(int'(lim_ok_hi) - 1, int'(lim_ok_lo) + 1));
        return 9'($urandom_range(VMAX, 0));
    endfunction

    task automatic send_sample(input logic [8:0] v, input logic fixed, input t_status want);
        int      gap;
        t_status predicted;
        gap = sender_idle ? int'($urandom_range(11, 0)) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample_valid   <= 1'b1;
        i_voltage_sample <= v;
        do @(posedge i_clk); while (!o_sample_ready);
        predicted = next_status(v);
        awaited_status_q.push_back(fixed ? want : predicted);
        n_samples++;
    endtask

    // let every awaited beat come back, then settle
    task automatic drain_results();
        @(negedge i_clk);
        i_sample_valid <= 1'b0;
        wait (awaited_status_q.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input mts_pkg::t_cfg_idx idx, input int val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 9'(val);
        case (idx)
            mts_pkg::CFG_FAIL_HIGH: lim_fail_hi = 9'(val);
            mts_pkg::CFG_FAIL_LOW:  lim_fail_lo = 9'(val);
            mts_pkg::CFG_OK_HIGH:   lim_ok_hi   = 9'(val);
            mts_pkg::CFG_OK_LOW:    lim_ok_lo   = 9'(val);
            mts_pkg::CFG_CONFIRM:   confirm_n   = 3'(val);
            mts_pkg::CFG_HOLD:      hold_n      = 6'(val);
            default: ;
        endcase
    endtask

    task automatic apply_phase(input int p);
        write_reg(mts_pkg::CFG_FAIL_HIGH, PH_FH[p]);
        write_reg(mts_pkg::CFG_FAIL_LOW,  PH_FL[p]);
        write_reg(mts_pkg::CFG_OK_HIGH,   PH_OH[p]);
        write_reg(mts_pkg::CFG_OK_LOW,    PH_OL[p]);
        write_reg(mts_pkg::CFG_CONFIRM,   PH_CF[p]);
        write_reg(mts_pkg::CFG_HOLD,      PH_HD[p]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // runs of in-band, failing or recovering samples, with some noise
    task automatic random_runs(input int count);
        int         sent;
        int         kind;
        int         len;
        logic [8:0] v;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(9, 0);
            len  = $urandom_range(9, 1);
            for (int k = 0; k < len && sent < count; k++) begin
                if (kind < 4)
                    v = 9'($urandom_range(BAND_CEIL[kind] - 1, BAND_FLOOR[kind] + 1));
                else if (kind < 6)
                    v = pick_fail();
                else if (kind < 8)
                    v = pick_ok();
                else
                    v = 9'($urandom_range(VMAX, 0));
                send_sample(v, 1'b0, ST_ANY);
                sent++;
                if (sent == count / 2) drain_results();
            end
        end
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (awaited_status_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual tap %0d",
                         $time, o_tap_select);
            end else begin
                want = awaited_status_q.pop_front();
                n_results++;
                if (o_tap_select !== want.tap)
                    note_mismatch("tap_select", int'(want.tap), int'(o_tap_select));
                if (o_drive_pattern !== want.pins)
                    note_mismatch("drive_pattern", int'(want.pins), int'(o_drive_pattern));
                if (o_sample_ok !== want.ok)
                    note_mismatch("sample_ok", int'(want.ok), int'(o_sample_ok));
                if (o_mains_failed !== want.failed)
                    note_mismatch("mains_failed", int'(want.failed), int'(o_mains_failed));
                if (o_failure_pending !== want.pending)
                    note_mismatch("failure_pending", int'(want.pending),
                                  int'(o_failure_pending));
                if (want.failed && !prev_failed) n_failures++;
                if (!want.failed && prev_failed) n_recoveries++;
                prev_failed = want.failed;
                taps_seen[want.tap] = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_sample_valid && o_sample_ready) || (o_result_valid && i_result_ready)
                    || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles == WATCHDOG_LIMIT) begin
                    $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = recv_idle ? int'($urandom_range(11, 0)) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                i_result_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_result_ready <= 1'b1;
            do @(posedge i_clk); while (!o_result_valid);
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = mts_pkg::CFG_FAIL_HIGH;
        i_cfg_data       = '0;
        i_sample_valid   = 1'b0;
        i_voltage_sample = '0;
        i_result_ready   = 1'b0;
        sender_idle      = 1'b1;
        recv_idle        = 1'b1;
        clear_model();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_sample(DIRECTED[i].volt, DIRECTED[i].fixed, DIRECTED[i].want);
        random_runs(PHASE_ITEMS);

        for (int p = 1; p < NUM_PHASES; p++) begin
            drain_results();
            apply_phase(p);
            sender_idle = (p % 4 == 0) || (p % 4 == 2);
            recv_idle   = (p % 4 == 0) || (p % 4 == 1);
            random_runs(PHASE_ITEMS);
        end

        @(negedge i_clk);
        i_sample_valid <= 1'b0;
        wait (awaited_status_q.size() == 0);
        repeat (8) @(posedge i_clk);

        $display("%0d samples over %0d threshold settings, %0d result beats checked",
                 n_samples, NUM_PHASES, n_results);
        $display("taps seen %b, failures declared %0d, recoveries %0d",
                 taps_seen, n_failures, n_recoveries);
        if (mismatches == 0 && awaited_status_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
